// ===== src/ritpc_pkg.sv =====
// Shared constants, types and helper functions for the range image to point cloud block.
// No dependencies; imported by ritpc_angle, range_image_to_point_cloud_top and the testbench.
package ritpc_pkg;

    // Sizes of fields and registers
    localparam int MAX_DIM      = 4096;
    localparam int COORD_WIDTH  = 32;
    localparam int IDX_W        = 12;
    localparam int DIM_W        = 13;
    localparam int FOV_W        = 17;
    localparam int CFG_W        = 17;
    localparam int DATA_W       = 32;

    // Angle units: 1/256 degree, full turn
    localparam int TURN         = 92160;
    localparam int HALF_TURN    = 46080;
    localparam int QUARTER_TURN = 23040;

    // Divider and modulo-by-turn reduction
    localparam int DIV_STEPS    = 31;
    localparam int MOD_RECIP    = 745654;   // floor(2^25 / 45)
    localparam int MOD_SHIFT    = 25;

    // CORDIC
    localparam int CORDIC_STEPS = 16;
    localparam int TRIG_W       = 34;
    localparam int ZANG_W       = 26;
    localparam int CORDIC_GAIN  = 652032874;

    localparam logic signed [ZANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        26'sd2949120, 26'sd1740968, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115
    };

    // Angle unit stages: two setup stages, divider, three reduction stages,
    // CORDIC and one output stage
    localparam int ANG_LAT      = 2 + DIV_STEPS + 3 + CORDIC_STEPS + 1;
    localparam int PROD_LAT     = 4;
    localparam int LAT          = ANG_LAT + PROD_LAT;

    localparam logic signed [69:0] COORD_MAX = (70'sd1 <<< (COORD_WIDTH - 1)) - 70'sd1;
    localparam logic signed [69:0] COORD_MIN = -COORD_MAX - 70'sd1;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_HORIZONTAL_FOV = 2'd2,
        REG_VERTICAL_FOV   = 2'd3
    } cfg_reg_t;

    typedef logic signed [TRIG_W-1:0] trig_t;

    typedef struct packed {
        logic [DIM_W-1:0] dim;
        logic [FOV_W-1:0] fov;
    } axis_cfg_t;

    // Round a Q30-scaled product to nearest and clamp to the coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] round_sat(input logic signed [69:0] v);
        logic signed [69:0] r;
        r = (v + 70'sd536870912) >>> 30;
        if (r > COORD_MAX)
        begin
            r = COORD_MAX;
        end
        else if (r < COORD_MIN)
        begin
            r = COORD_MIN;
        end
        return r[COORD_WIDTH-1:0];
    endfunction

endpackage

// ===== src/range_image_to_point_cloud_top.sv =====
// Top level: range image pixel to Cartesian point, config registers and stall control.
// Depends on ritpc_pkg and ritpc_angle (one instance per axis).
//
// Usage
//   Input channel: in_valid / in_stall carry one pixel per beat (row, column,
//   range, not-finite flag, intensity, frame end). Output channel: out_valid /
//   out_stall carry one point per beat; every pixel yields exactly one point,
//   with point_valid low and zero coordinates for a non-finite or non-positive
//   range. Amplitude and frame_end_out pass through.
//   Config: cfg_write, cfg_index, cfg_data write the frame size and fields of
//   view; write only while no beats are in flight.
//   A beat runs through the angle units (31-step divider and 16-step CORDIC)
//   and then the product stages. One beat is accepted every cycle while
//   in_stall is low.
//   When out_stall holds a valid output, the whole pipeline freezes and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset empties the pipeline and loads the default frame geometry
//   (512 x 64, 90 by 30 degrees).
module range_image_to_point_cloud_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [1:0]                           cfg_index,
    input  logic [ritpc_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [ritpc_pkg::IDX_W-1:0]          row_index,
    input  logic [ritpc_pkg::IDX_W-1:0]          col_index,
    input  logic signed [ritpc_pkg::DATA_W-1:0]  range_value,
    input  logic                                 range_not_finite,
    input  logic [ritpc_pkg::DATA_W-1:0]         intensity_word,
    input  logic                                 frame_end_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [ritpc_pkg::COORD_WIDTH-1:0] point_x,
    output logic signed [ritpc_pkg::COORD_WIDTH-1:0] point_y,
    output logic signed [ritpc_pkg::COORD_WIDTH-1:0] point_z,
    output logic [ritpc_pkg::DATA_W-1:0]         amplitude,
    output logic                                 point_valid,
    output logic                                 frame_end_out
);
    import ritpc_pkg::*;

    typedef struct packed {
        logic              pt_ok;
        logic              frame_end;
        logic [DATA_W-1:0] amp;
    } side_t;

    // Configuration registers
    logic [DIM_W-1:0] frame_width_reg, frame_height_reg;
    logic [FOV_W-1:0] horizontal_fov_reg, vertical_fov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= DIM_W'(512);
            frame_height_reg   <= DIM_W'(64);
            horizontal_fov_reg <= FOV_W'(23040);
            vertical_fov_reg   <= FOV_W'(7680);
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[DIM_W-1:0];
                REG_HORIZONTAL_FOV: horizontal_fov_reg <= cfg_data[FOV_W-1:0];
                REG_VERTICAL_FOV:   vertical_fov_reg   <= cfg_data[FOV_W-1:0];
                default:            frame_width_reg    <= frame_width_reg;
            endcase
        end
    end

    // Pipeline advance: freeze everything while the output beat is held
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign in_stall = vld_reg[LAT-1] && out_stall;
    assign en       = !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // Side data travels alongside the angle units
    side_t                    side_reg [LAT];
    logic signed [DATA_W-1:0] rng_reg  [ANG_LAT];
    side_t                    side_next;

    always_comb
    begin
        side_next.pt_ok     = !range_not_finite && (range_value > 0);
        side_next.frame_end = frame_end_in;
        side_next.amp       = intensity_word;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            rng_reg[0]  <= range_value;
            for (int s = 1; s < LAT; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            for (int s = 1; s < ANG_LAT; s++)
            begin
                rng_reg[s] <= rng_reg[s-1];
            end
        end
    end

    // Azimuth and elevation units
    axis_cfg_t az_cfg, el_cfg;
    trig_t     caz, saz, cel, sel;

    assign az_cfg = '{dim: frame_width_reg,  fov: horizontal_fov_reg};
    assign el_cfg = '{dim: frame_height_reg, fov: vertical_fov_reg};

    ritpc_angle u_az (
        .clk     (clk),
        .en      (en),
        .idx     (col_index),
        .acfg    (az_cfg),
        .cos_val (caz),
        .sin_val (saz)
    );

    ritpc_angle u_el (
        .clk     (clk),
        .en      (en),
        .idx     (row_index),
        .acfg    (el_cfg),
        .cos_val (cel),
        .sin_val (sel)
    );

    // Product stage 1: r*cos(el), r*sin(el)
    logic signed [65:0] prc_reg, prs_reg;
    trig_t              caz1_reg, saz1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prc_reg  <= rng_reg[ANG_LAT-1] * cel;
            prs_reg  <= rng_reg[ANG_LAT-1] * sel;
            caz1_reg <= caz;
            saz1_reg <= saz;
        end
    end

    // Product stage 2: round t, finish y
    logic signed [65:0]            trnd;
    logic signed [35:0]            t_reg;
    logic signed [COORD_WIDTH-1:0] y2_reg;
    trig_t                         caz2_reg, saz2_reg;

    assign trnd = (prc_reg + 66'sd536870912) >>> 30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg    <= trnd[35:0];
            y2_reg   <= round_sat(70'(prs_reg));
            caz2_reg <= caz1_reg;
            saz2_reg <= saz1_reg;
        end
    end

    // Product stage 3: t*sin(az), t*cos(az)
    logic signed [69:0]            prx_reg, prz_reg;
    logic signed [COORD_WIDTH-1:0] y3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prx_reg <= t_reg * saz2_reg;
            prz_reg <= t_reg * caz2_reg;
            y3_reg  <= y2_reg;
        end
    end

    // Product stage 4: round, saturate, zero invalid points
    logic signed [COORD_WIDTH-1:0] x_reg, y_reg, z_reg;
    logic                          ok3;

    assign ok3 = side_reg[LAT-2].pt_ok;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= ok3 ? round_sat(prx_reg) : '0;
            z_reg <= ok3 ? round_sat(prz_reg) : '0;
            y_reg <= ok3 ? y3_reg : '0;
        end
    end

    assign out_valid     = vld_reg[LAT-1];
    assign point_x       = x_reg;
    assign point_y       = y_reg;
    assign point_z       = z_reg;
    assign amplitude     = side_reg[LAT-1].amp;
    assign point_valid   = side_reg[LAT-1].pt_ok;
    assign frame_end_out = side_reg[LAT-1].frame_end;

    // Checks
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !point_valid) |-> (point_x == 0 && point_y == 0 && point_z == 0))
        else $error("invalid point carries nonzero coordinates");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(vld_reg))
        else $error("pipeline moved while output was held");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no output beat waiting");

endmodule

// ===== src/ritpc_angle.sv =====
// Angle unit: pixel index to cosine and sine of its axis angle (Q2.30).
// Pipelined divider, modulo-turn reduction and 16-step CORDIC; uses ritpc_pkg.
module ritpc_angle (
    input  logic                       clk,
    input  logic                       en,
    input  logic [ritpc_pkg::IDX_W-1:0] idx,
    input  ritpc_pkg::axis_cfg_t       acfg,
    output ritpc_pkg::trig_t           cos_val,
    output ritpc_pkg::trig_t           sin_val
);
    import ritpc_pkg::*;

    // Config geometry; the user holds it steady while beats are in flight, unenforced
    logic [DIM_W-1:0] nsat;
    logic [IDX_W-1:0] span;
    logic [DIM_W-1:0] den;
    logic             axis_flat;

    always_comb
    begin
        nsat      = (acfg.dim > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : acfg.dim;
        axis_flat = (nsat < DIM_W'(2));
        span      = axis_flat ? '0 : IDX_W'(nsat - DIM_W'(1));
        den       = {span, 1'b0};
    end

    // Stage 1: numerator fov * (2*idx - (n-1))
    logic signed [13:0] ofs;
    logic signed [31:0] num_next, num_reg;

    always_comb
    begin
        ofs      = $signed({1'b0, idx, 1'b0}) - $signed({2'b00, span});
        num_next = $signed({1'b0, acfg.fov}) * ofs;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
        end
    end

    // Stage 2: magnitude plus half divisor for round-to-nearest
    logic [31:0]          mag;
    logic [DIV_STEPS-1:0] dd_next, dd_reg;
    logic                 neg_reg;

    always_comb
    begin
        mag     = num_reg[31] ? 32'(-num_reg) : 32'(num_reg);
        dd_next = DIV_STEPS'(mag + 32'(span));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg  <= dd_next;
            neg_reg <= num_reg[31];
        end
    end

    // Divider: one quotient bit per stage, restoring
    logic [DIM_W-1:0]     dv_rem_in   [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] dv_word_in  [DIV_STEPS+1];
    logic                 dv_neg_in   [DIV_STEPS+1];
    logic [DIM_W:0]       dv_trial    [DIV_STEPS];
    logic                 dv_ge       [DIV_STEPS];
    logic [DIM_W-1:0]     dv_rem_next [DIV_STEPS];
    logic [DIV_STEPS-1:0] dv_word_next[DIV_STEPS];
    logic [DIM_W-1:0]     dv_rem_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] dv_word_reg [DIV_STEPS];
    logic                 dv_neg_reg  [DIV_STEPS];

    always_comb
    begin
        dv_rem_in[0]  = '0;
        dv_word_in[0] = dd_reg;
        dv_neg_in[0]  = neg_reg;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            dv_rem_in[k+1]  = dv_rem_reg[k];
            dv_word_in[k+1] = dv_word_reg[k];
            dv_neg_in[k+1]  = dv_neg_reg[k];
        end
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            dv_trial[k]     = {dv_rem_in[k], dv_word_in[k][DIV_STEPS-1]};
            dv_ge[k]        = (dv_trial[k] >= {1'b0, den});
            dv_rem_next[k]  = dv_ge[k] ? DIM_W'(dv_trial[k] - {1'b0, den})
                                       : dv_trial[k][DIM_W-1:0];
            dv_word_next[k] = {dv_word_in[k][DIV_STEPS-2:0], dv_ge[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dv_rem_reg[k]  <= dv_rem_next[k];
                dv_word_reg[k] <= dv_word_next[k];
                dv_neg_reg[k]  <= dv_neg_in[k];
            end
        end
    end

    // Reduction M1: quotient / 2048 times reciprocal of 45
    logic [DIV_STEPS-1:0] quot;
    logic [19:0]          mv_next, mv_reg;
    logic [39:0]          mp_next, mp_reg;
    logic [10:0]          m1_lo_reg;
    logic                 m1_neg_reg;

    always_comb
    begin
        quot    = dv_word_reg[DIV_STEPS-1];
        mv_next = quot[DIV_STEPS-1:11];
        mp_next = mv_next * 20'(MOD_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mv_reg     <= mv_next;
            mp_reg     <= mp_next;
            m1_lo_reg  <= quot[10:0];
            m1_neg_reg <= dv_neg_reg[DIV_STEPS-1];
        end
    end

    // Reduction M2: remainder modulo 45, one correction
    logic [14:0] mk;
    logic [20:0] mr;
    logic [6:0]  mr7;
    logic [5:0]  rm_next, rm_reg;
    logic [10:0] m2_lo_reg;
    logic        m2_neg_reg;

    always_comb
    begin
        mk      = mp_reg[39:MOD_SHIFT];
        mr      = {1'b0, mv_reg} - 21'(21'(mk) * 21'd45);
        mr7     = mr[6:0];
        rm_next = (mr7 >= 7'd45) ? 6'(mr7 - 7'd45) : mr7[5:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rm_reg     <= rm_next;
            m2_lo_reg  <= m1_lo_reg;
            m2_neg_reg <= m1_neg_reg;
        end
    end

    // Reduction M3: wrap to half turn, fold into quarter turn, scale to 1/65536 degree
    logic [16:0]              full;
    logic [16:0]              pos;
    logic signed [17:0]       wa;
    logic signed [17:0]       fa;
    logic                     flip_next;
    logic signed [ZANG_W-1:0] z3_next, z3_reg;
    logic                     flip3_reg;

    always_comb
    begin
        full = {rm_reg, m2_lo_reg};
        if (axis_flat)
        begin
            pos = '0;
        end
        else if (m2_neg_reg && (full != '0))
        begin
            pos = 17'(TURN) - full;
        end
        else
        begin
            pos = full;
        end
        if (pos >= 17'(HALF_TURN))
        begin
            wa = $signed({1'b0, pos}) - $signed(18'(TURN));
        end
        else
        begin
            wa = $signed({1'b0, pos});
        end
        flip_next = 1'b0;
        fa        = wa;
        if (wa > $signed(18'(QUARTER_TURN)))
        begin
            fa        = wa - $signed(18'(HALF_TURN));
            flip_next = 1'b1;
        end
        else if (wa < -$signed(18'(QUARTER_TURN)))
        begin
            fa        = wa + $signed(18'(HALF_TURN));
            flip_next = 1'b1;
        end
        z3_next = {fa, 8'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z3_reg    <= z3_next;
            flip3_reg <= flip_next;
        end
    end

    // CORDIC rotation, one step per stage
    trig_t                    cx_in  [CORDIC_STEPS+1];
    trig_t                    cy_in  [CORDIC_STEPS+1];
    logic signed [ZANG_W-1:0] cz_in  [CORDIC_STEPS+1];
    logic                     cf_in  [CORDIC_STEPS+1];
    trig_t                    cx_next[CORDIC_STEPS];
    trig_t                    cy_next[CORDIC_STEPS];
    logic signed [ZANG_W-1:0] cz_next[CORDIC_STEPS];
    trig_t                    cx_reg [CORDIC_STEPS];
    trig_t                    cy_reg [CORDIC_STEPS];
    logic signed [ZANG_W-1:0] cz_reg [CORDIC_STEPS];
    logic                     cf_reg [CORDIC_STEPS];

    always_comb
    begin
        cx_in[0] = TRIG_W'(CORDIC_GAIN);
        cy_in[0] = '0;
        cz_in[0] = z3_reg;
        cf_in[0] = flip3_reg;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            cx_in[i+1] = cx_reg[i];
            cy_in[i+1] = cy_reg[i];
            cz_in[i+1] = cz_reg[i];
            cf_in[i+1] = cf_reg[i];
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (cz_in[i] >= 0)
            begin
                cx_next[i] = cx_in[i] - (cy_in[i] >>> i);
                cy_next[i] = cy_in[i] + (cx_in[i] >>> i);
                cz_next[i] = cz_in[i] - ATAN_TAB[i];
            end
            else
            begin
                cx_next[i] = cx_in[i] + (cy_in[i] >>> i);
                cy_next[i] = cy_in[i] - (cx_in[i] >>> i);
                cz_next[i] = cz_in[i] + ATAN_TAB[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                cz_reg[i] <= cz_next[i];
                cf_reg[i] <= cf_in[i];
            end
        end
    end

    // Output stage: undo the half-turn fold
    trig_t cos_reg, sin_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cf_in[CORDIC_STEPS] ? -cx_in[CORDIC_STEPS] : cx_in[CORDIC_STEPS];
            sin_reg <= cf_in[CORDIC_STEPS] ? -cy_in[CORDIC_STEPS] : cy_in[CORDIC_STEPS];
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

// ===== bench/range_image_to_point_cloud_top_tb.sv =====
// Testbench for range_image_to_point_cloud_top: pixel beats in, Cartesian point beats out.
// Depends on ritpc_pkg and the RTL of the block; self-checking against an in-bench projector.
module range_image_to_point_cloud_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ritpc_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic signed [DATA_W-1:0] range_value;
    logic range_not_finite;
    logic [DATA_W-1:0] intensity_word;
    logic frame_end_in;
    logic out_valid;
    logic out_stall;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic [DATA_W-1:0] amplitude;
    logic point_valid;
    logic frame_end_out;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0] amp;
        logic valid;
        logic fend;
    } point_t;

    point_t pending_points[$];
    int errors;
    int beats_sent;
    int points_seen;
    int stall_mode;
    int hold_left;
    logic [12:0] geo_width;
    logic [12:0] geo_height;
    logic [16:0] geo_hfov;
    logic [16:0] geo_vfov;

    const longint atan_steps[16] = '{
        2949120, 1740968, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    range_image_to_point_cloud_top uut (.*);

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Angle in 1/256 degree from index, dimension and field of view
    function automatic longint bin_angle(longint idx, longint n, longint fov);
        longint num;
        longint den;
        longint mag;
        longint q;
        if (n > MAX_DIM)
        begin
            n = MAX_DIM;
        end
        if (n < 2)
        begin
            return 0;
        end
        num = fov * (2 * idx - (n - 1));
        den = 2 * (n - 1);
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // Rotate the gain vector through the angle; returns cosine and sine in Q2.30
    task automatic rotate_angle(input longint ang, output longint c, output longint s);
        longint a;
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        bit flip;
        a = ang % TURN;
        x = CORDIC_GAIN;
        y = 0;
        flip = 0;
        if (a < 0)
        begin
            a += TURN;
        end
        if (a >= HALF_TURN)
        begin
            a -= TURN;
        end
        if (a > QUARTER_TURN)
        begin
            a -= HALF_TURN;
            flip = 1;
        end
        else if (a < -QUARTER_TURN)
        begin
            a += HALF_TURN;
            flip = 1;
        end
        z = a * 256;
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= atan_steps[i];
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += atan_steps[i];
            end
            x = nx;
            y = ny;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint round_clamp(longint v);
        longint r;
        r = (v + (64'sd1 <<< 29)) >>> 30;
        if (r > 64'sd2147483647)
        begin
            r = 64'sd2147483647;
        end
        if (r < -64'sd2147483648)
        begin
            r = -64'sd2147483648;
        end
        return r;
    endfunction

    // Project one pixel to its expected point
    task automatic project_pixel(input logic [11:0] row, input logic [11:0] col,
                                 input logic signed [31:0] rng, input logic nf,
                                 input logic [31:0] inten, input logic fe);
        point_t p;
        longint caz;
        longint saz;
        longint cel;
        longint sel;
        longint t;
        longint r;
        p = '0;
        r = rng;
        p.valid = !nf && r > 0;
        p.amp = inten;
        p.fend = fe;
        if (p.valid)
        begin
            rotate_angle(bin_angle(col, geo_width, geo_hfov), caz, saz);
            rotate_angle(bin_angle(row, geo_height, geo_vfov), cel, sel);
            t = (r * cel + (64'sd1 <<< 29)) >>> 30;
            p.x = 32'(round_clamp(t * saz));
            p.z = 32'(round_clamp(t * caz));
            p.y = 32'(round_clamp(r * sel));
        end
        pending_points = {pending_points, p};
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 7)
        begin
            return 0;
        end
        if ($urandom_range(0, 9) < 8)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Send one pixel beat, with a random gap before it when stall_mode is nonzero
    task automatic send_pixel(input int row, input int col,
                              input logic signed [31:0] rng, input int nf,
                              input logic [31:0] inten, input int fe);
        int gap;
        gap = (stall_mode != 0) ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        row_index <= IDX_W'(row);
        col_index <= IDX_W'(col);
        range_value <= rng;
        range_not_finite <= 1'(nf);
        intensity_word <= inten;
        frame_end_in <= 1'(fe);
        project_pixel(12'(row), 12'(col), rng, 1'(nf), inten, 1'(fe));
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        beats_sent++;
    endtask

    task automatic drain_points();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LAT + 8) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH: geo_width = 13'(val);
            REG_FRAME_HEIGHT: geo_height = 13'(val);
            REG_HORIZONTAL_FOV: geo_hfov = 17'(val);
            default: geo_vfov = 17'(val);
        endcase
        @(posedge clk);
    endtask

    task automatic set_geometry(input int w, input int h, input int hf, input int vf);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_HORIZONTAL_FOV, hf);
        write_reg(REG_VERTICAL_FOV, vf);
    endtask

    function automatic logic signed [31:0] rand_range();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(1, 32'h7fff);
            2: return 32'h7fffffff - $urandom_range(0, 1000);
            default: return $urandom_range(1, 32'h00ff_ffff);
        endcase
    endfunction

    // Extremes of fields and the invalid-range cases under reset geometry
    task automatic test_directed();
        send_pixel(0, 0, 32'h0001_0000, 0, 32'hffffffff, 0);
        send_pixel(63, 511, 32'h7fffffff, 0, 32'h0, 0);
        send_pixel(4095, 4095, 32'h7fffffff, 0, 32'h12345678, 1);
        send_pixel(32, 256, 32'h0, 0, 32'ha5a5a5a5, 0);
        send_pixel(10, 20, 32'h80000000, 0, 32'h5a5a5a5a, 0);
        send_pixel(10, 20, 32'hffffffff, 0, 32'h1, 0);
        send_pixel(10, 20, 32'h0010_0000, 1, 32'h2, 1);
        send_pixel(1, 1, 32'h1, 0, 32'h3, 0);
        send_pixel(2048, 1024, 32'h0100_0000, 0, 32'h4, 1);
        drain_points();
    endtask

    // Zero and unit dimensions, oversized dimensions, and wide and zero fields of view
    task automatic test_geometry_edges();
        set_geometry(1, 0, 92160, 92160);
        send_pixel(0, 0, 32'h0002_0000, 0, 32'h11, 0);
        send_pixel(4095, 4095, 32'h0002_0000, 0, 32'h12, 1);
        drain_points();
        set_geometry(8191, 8191, 131071, 131071);
        send_pixel(0, 0, 32'h0003_0000, 0, 32'h13, 0);
        send_pixel(4095, 4095, 32'h0003_0000, 0, 32'h14, 0);
        send_pixel(2000, 100, 32'h7fffffff, 0, 32'h15, 1);
        drain_points();
        set_geometry(2, 2, 0, 0);
        send_pixel(0, 1, 32'h0003_0000, 0, 32'h16, 0);
        send_pixel(4095, 4095, 32'h7fffffff, 0, 32'h17, 1);
        drain_points();
    endtask

    // Random frames under several geometries
    task automatic test_random_frames();
        int w;
        int h;
        for (int phase = 0; phase < 6; phase++)
        begin
            w = $urandom_range(1, 4200);
            h = $urandom_range(1, 4200);
            set_geometry(w, h, $urandom_range(0, 92160), $urandom_range(0, 92160));
            stall_mode = phase % 3;
            for (int k = 0; k < 300; k++)
            begin
                send_pixel($urandom_range(0, 7) == 0 ? $urandom_range(0, 4095)
                               : $urandom_range(0, (h > 1 ? h - 1 : 0)),
                           $urandom_range(0, 7) == 0 ? $urandom_range(0, 4095)
                               : $urandom_range(0, (w > 1 ? w - 1 : 0)),
                           rand_range(), ($urandom_range(0, 15) == 0),
                           $urandom, ($urandom_range(0, 31) == 0));
            end
            drain_points();
        end
        stall_mode = 1;
    endtask

    // Receiver stall and output check
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (stall_mode == 0)
            begin
                out_stall <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if ($urandom_range(0, 9) < 3)
            begin
                out_stall <= 1'b1;
                hold_left <= gap_len();
            end
            else
            begin
                out_stall <= 1'b0;
            end
            if (out_valid && !out_stall)
            begin
                points_seen++;
                if (pending_points.size() == 0)
                begin
                    $display("%t: unexpected point x=%0d", $realtime, point_x);
                    errors++;
                end
                else
                begin
                    point_t e;
                    e = pending_points.pop_front();
                    if (point_x !== e.x || point_y !== e.y || point_z !== e.z
                        || amplitude !== e.amp || point_valid !== e.valid
                        || frame_end_out !== e.fend)
                    begin
                        $display("%t: expected x=%0d y=%0d z=%0d amp=%h v=%b fe=%b", $realtime,
                                 e.x, e.y, e.z, e.amp, e.valid, e.fend);
                        $display("%t: actual   x=%0d y=%0d z=%0d amp=%h v=%b fe=%b", $realtime,
                                 point_x, point_y, point_z, amplitude, point_valid,
                                 frame_end_out);
                        errors++;
                    end
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #20ms;
        $display("range_image_to_point_cloud_top_tb failed");
        $finish;
    end

    initial
    begin
        errors = 0;
        beats_sent = 0;
        points_seen = 0;
        stall_mode = 1;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        row_index = '0;
        col_index = '0;
        range_value = '0;
        range_not_finite = 1'b0;
        intensity_word = '0;
        frame_end_in = 1'b0;
        geo_width = 512;
        geo_height = 64;
        geo_hfov = 23040;
        geo_vfov = 7680;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_geometry_edges();
        test_random_frames();
        $display("Sent %0d pixel beats over several geometries, checked %0d points.",
                 beats_sent, points_seen);
        if (errors == 0)
        begin
            $display("range_image_to_point_cloud_top_tb passed");
        end
        else
        begin
            $display("range_image_to_point_cloud_top_tb failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
src/ritpc_pkg.sv
src/ritpc_angle.sv
src/range_image_to_point_cloud_top.sv
bench/range_image_to_point_cloud_top_tb.sv
